### rtl/v4m_pkg.sv
package v4m_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int EW         = 32;
    localparam int NUM_PAIRS  = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int NUM_BITS   = EW + FRAC_BITS;
    localparam int SQRT_STEPS = EW;
    localparam int DIV_STEPS  = NUM_BITS;
    localparam int CHAIN_N    = SQRT_STEPS + DIV_STEPS + 2;
    localparam int IN_W       = 264;
    localparam int OUT_W      = 168;
    localparam int SAT_W      = 2 * EW + 4;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_NEG   = 4'd4;
    localparam logic [3:0] OP_DOT   = 4'd5;
    localparam logic [3:0] OP_LEN   = 4'd6;
    localparam logic [3:0] OP_NORM  = 4'd7;
    localparam logic [3:0] OP_DIST  = 4'd8;
    localparam logic [3:0] OP_XFORM = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_NE    = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [NUM_PAIRS-1:0][63:0] MAT_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0001_0000_0000
    };

    typedef struct packed {
        logic [3:0]           op;
        logic                 need_len;
        logic                 need_div;
        logic [3:0][EW-1:0]   a;
        logic [3:0][EW-1:0]   b;
        logic [3:0][EW:0]     diff;
        logic                 eq;
    } item_t;

endpackage

### rtl/v4m_front.sv
module v4m_front
    import v4m_pkg::*;
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    output logic            push,
    input  logic            push_ready,
    output item_t           item
);

    logic [3:0] op;

    assign op       = s_tdata[3:0];
    assign push     = s_tvalid;
    assign s_tready = push_ready;

    always_comb
    begin
        item.op       = op;
        item.need_len = (op == OP_LEN) || (op == OP_NORM) || (op == OP_DIST);
        item.need_div = (op == OP_DIV) || (op == OP_NORM);
        item.eq       = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            item.a[i]    = s_tdata[4 + EW * i +: EW];
            item.b[i]    = s_tdata[4 + EW * (4 + i) +: EW];
            item.diff[i] = (EW + 1)'($signed(item.a[i])) - (EW + 1)'($signed(item.b[i]));
            if (item.a[i] != item.b[i])
            begin
                item.eq = 1'b0;
            end
        end
    end

endmodule

### rtl/v4m_queue.sv
module v4m_queue
    import v4m_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  item_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output item_t rd_data
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/v4m_back.sv
module v4m_back
    import v4m_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [63:0]          cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  item_t                q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata
);

    typedef struct packed {
        logic [3:0]                op;
        logic                      need_len;
        logic                      need_div;
        logic [3:0][EW-1:0]        a;
        logic [3:0][EW-1:0]        b;
        logic [3:0][2*EW+1:0]      lp;
        logic [15:0][2*EW-1:0]     mp;
        logic                      eq;
    } prod_t;

    typedef struct packed {
        logic [3:0]                op;
        logic                      need_div;
        logic [3:0][EW-1:0]        rv;
        logic [EW-1:0]             scalar;
        logic                      flag;
        logic                      clip;
        logic                      dz;
        logic [2*EW-1:0]           rad;
        logic [EW+1:0]             srem;
        logic [EW-1:0]             root;
        logic [3:0][NUM_BITS-1:0]  num;
        logic [3:0][EW-1:0]        drem;
        logic [3:0][NUM_BITS-1:0]  quo;
        logic [3:0][EW-1:0]        den;
        logic [3:0]                qneg;
        logic [3:0]                dzl;
    } wk_t;

    logic [NUM_PAIRS-1:0][63:0] mat_reg;
    logic                       adv;
    prod_t                      p_reg;
    prod_t                      p_next;
    logic                       p_vld_reg;
    wk_t                        chain_reg  [CHAIN_N];
    wk_t                        chain_next [CHAIN_N];
    logic [CHAIN_N-1:0]         cvld_reg;
    logic [OUT_W-1:0]           out_reg;
    logic [OUT_W-1:0]           out_next;
    logic                       out_vld_reg;

    function automatic logic [EW:0] sat_w(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'({1'b0, {(EW - 1){1'b1}}});
        lo = -hi - SAT_W'(1);
        if (v > hi)
        begin
            return {1'b1, 1'b0, {(EW - 1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, 1'b1, {(EW - 1){1'b0}}};
        end
        return {1'b0, v[EW-1:0]};
    endfunction

    function automatic logic [EW-1:0] mag(input logic [EW-1:0] v);
        return v[EW-1] ? (EW)'(-v) : v;
    endfunction

    function automatic wk_t setup(input prod_t p);
        wk_t                     o;
        logic [EW:0]             s;
        logic signed [SAT_W-1:0] acc;
        logic [SAT_W-1:0]        usum;
        o = '0;
        o.op       = p.op;
        o.need_div = p.need_div;
        case (p.op)
            OP_ADD, OP_SUB, OP_NEG, OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (p.op == OP_ADD)
                    begin
                        acc = SAT_W'($signed(p.a[i])) + SAT_W'($signed(p.b[i]));
                    end
                    else if (p.op == OP_SUB)
                    begin
                        acc = SAT_W'($signed(p.a[i])) - SAT_W'($signed(p.b[i]));
                    end
                    else if (p.op == OP_NEG)
                    begin
                        acc = -SAT_W'($signed(p.a[i]));
                    end
                    else
                    begin
                        acc = SAT_W'($signed(p.lp[i]) >>> FRAC_BITS);
                    end
                    s = sat_w(acc);
                    o.rv[i] = s[EW-1:0];
                    o.clip  = o.clip | s[EW];
                end
            end
            OP_DOT:
            begin
                acc = '0;
                for (int i = 0; i < 4; i++)
                begin
                    acc = acc + SAT_W'($signed(p.lp[i]) >>> FRAC_BITS);
                end
                s = sat_w(acc);
                o.scalar = s[EW-1:0];
                o.clip   = s[EW];
            end
            OP_XFORM:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    acc = '0;
                    for (int j = 0; j < 4; j++)
                    begin
                        acc = acc + SAT_W'($signed(p.mp[i + 4 * j]) >>> FRAC_BITS);
                    end
                    s = sat_w(acc);
                    o.rv[i] = s[EW-1:0];
                    o.clip  = o.clip | s[EW];
                end
            end
            OP_EQ:
            begin
                o.flag = p.eq;
            end
            OP_NE:
            begin
                o.flag = ~p.eq;
            end
            default:
            begin
                o.flag = 1'b0;
            end
        endcase
        if (p.need_len)
        begin
            usum = '0;
            for (int i = 0; i < 4; i++)
            begin
                usum = usum + SAT_W'(p.lp[i]);
            end
            if (usum > SAT_W'({(2 * EW){1'b1}}))
            begin
                o.rad = '1;
            end
            else
            begin
                o.rad = usum[2*EW-1:0];
            end
        end
        if (p.need_div)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o.num[i] = {mag(p.a[i]), {FRAC_BITS{1'b0}}};
                if (p.op == OP_DIV)
                begin
                    o.den[i]  = mag(p.b[i]);
                    o.qneg[i] = p.a[i][EW-1] ^ p.b[i][EW-1];
                    o.dzl[i]  = (p.b[i] == '0);
                end
                else
                begin
                    o.qneg[i] = p.a[i][EW-1];
                end
            end
        end
        return o;
    endfunction

    function automatic wk_t sqrt_step(input wk_t w);
        wk_t           o;
        logic [EW+3:0] rem2;
        logic [EW+3:0] trial;
        o     = w;
        rem2  = {w.srem, w.rad[2*EW-1:2*EW-2]};
        trial = {2'b00, w.root, 2'b01};
        if (rem2 >= trial)
        begin
            o.srem = (EW + 2)'(rem2 - trial);
            o.root = {w.root[EW-2:0], 1'b1};
        end
        else
        begin
            o.srem = rem2[EW+1:0];
            o.root = {w.root[EW-2:0], 1'b0};
        end
        o.rad = {w.rad[2*EW-3:0], 2'b00};
        return o;
    endfunction

    function automatic wk_t post_sqrt(input wk_t w);
        wk_t         o;
        logic [EW:0] s;
        o = w;
        s = sat_w(SAT_W'(w.root));
        if ((w.op == OP_LEN) || (w.op == OP_DIST))
        begin
            o.scalar = s[EW-1:0];
            o.clip   = s[EW];
        end
        if (w.op == OP_NORM)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o.den[i] = w.root;
            end
            if (w.root == '0)
            begin
                o.dz  = 1'b1;
                o.dzl = '1;
            end
        end
        return o;
    endfunction

    function automatic wk_t div_step(input wk_t w);
        wk_t         o;
        logic [EW:0] rem2;
        o = w;
        for (int i = 0; i < 4; i++)
        begin
            rem2 = {w.drem[i], w.num[i][NUM_BITS-1]};
            if (rem2 >= {1'b0, w.den[i]})
            begin
                o.drem[i] = (EW)'(rem2 - {1'b0, w.den[i]});
                o.quo[i]  = {w.quo[i][NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                o.drem[i] = rem2[EW-1:0];
                o.quo[i]  = {w.quo[i][NUM_BITS-2:0], 1'b0};
            end
            o.num[i] = {w.num[i][NUM_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [OUT_W-1:0] finish(input wk_t w);
        wk_t                     o;
        logic [EW:0]             s;
        logic signed [SAT_W-1:0] v;
        logic [1:0]              st;
        o = w;
        if (w.need_div)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (w.dzl[i])
                begin
                    o.rv[i] = '0;
                    o.dz    = 1'b1;
                end
                else
                begin
                    v = w.qneg[i] ? -SAT_W'(w.quo[i]) : SAT_W'(w.quo[i]);
                    s = sat_w(v);
                    o.rv[i] = s[EW-1:0];
                    o.clip  = o.clip | s[EW];
                end
            end
        end
        st = o.dz ? ST_DIVZ : (o.clip ? ST_SAT : ST_OK);
        return OUT_W'({st, o.flag, o.scalar, o.rv[3], o.rv[2], o.rv[1], o.rv[0]});
    endfunction

    assign adv      = !out_vld_reg || m_tready;
    assign q_ready  = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        logic [3:0][EW:0] x;
        logic [3:0][EW:0] y;
        p_next.op       = q_item.op;
        p_next.need_len = q_item.need_len;
        p_next.need_div = q_item.need_div;
        p_next.a        = q_item.a;
        p_next.b        = q_item.b;
        p_next.eq       = q_item.eq;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = (EW + 1)'($signed(q_item.a[i]));
            y[i] = (EW + 1)'($signed(q_item.b[i]));
            if ((q_item.op == OP_LEN) || (q_item.op == OP_NORM))
            begin
                y[i] = x[i];
            end
            else if (q_item.op == OP_DIST)
            begin
                x[i] = q_item.diff[i];
                y[i] = q_item.diff[i];
            end
            p_next.lp[i] = (2 * EW + 2)'($signed(x[i])) * (2 * EW + 2)'($signed(y[i]));
        end
        for (int k = 0; k < 16; k++)
        begin
            p_next.mp[k] = (2 * EW)'($signed(mat_reg[k / 2][32 * (k % 2) +: EW]))
                         * (2 * EW)'($signed(q_item.a[k / 4]));
        end
    end

    assign chain_next[0]              = setup(p_reg);
    assign chain_next[SQRT_STEPS + 1] = post_sqrt(chain_reg[SQRT_STEPS]);

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        assign chain_next[k] = sqrt_step(chain_reg[k-1]);
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        assign chain_next[SQRT_STEPS + 2 + k] = div_step(chain_reg[SQRT_STEPS + 1 + k]);
    end

    assign out_next = finish(chain_reg[CHAIN_N-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg     <= MAT_RESET;
            p_vld_reg   <= 1'b0;
            cvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_PAIRS)))
            begin
                mat_reg[cfg_idx[$clog2(NUM_PAIRS)-1:0]] <= cfg_data;
            end
            if (adv)
            begin
                p_vld_reg   <= q_valid;
                cvld_reg    <= {cvld_reg[CHAIN_N-2:0], p_vld_reg};
                out_vld_reg <= cvld_reg[CHAIN_N-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg   <= p_next;
            out_reg <= out_next;
            for (int k = 0; k < CHAIN_N; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
        end
    end

endmodule

### rtl/vec4_math_unit.sv
// Four-element Q16.16 vector unit with a column-major 4x4 transform matrix.
// Input channel s_*: one transaction carries an opcode and vectors a and b.
// Output channel m_*: exactly one result transaction per input transaction,
// in order: result vector, scalar, compare flag and status.
// Configuration: cfg_we writes cfg_data to matrix pair cfg_idx (0..7) at the
// clock edge; higher indexes are dropped. Write only while the unit is idle.
// Throughput: one transaction per cycle, sustained while m_tready is high.
// Every transaction passes through the 32-step square-root chain followed by
// the 48-step division chain, one step per stage.
// A two-entry queue separates the input decoder from the arithmetic pipeline.
// When m_tready is low with a result waiting, the whole pipeline holds and
// the queue absorbs up to two more transactions before s_tready drops.
// Reset clears all valid state and loads the default matrix pairs.
module vec4_math_unit
    import v4m_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [63:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, zero pad
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // r_x, r_y, r_z, r_w, scalar_out, compare_flag, status, zero pad
    output logic [OUT_W-1:0]     m_tdata
);

    logic  push;
    logic  push_ready;
    item_t item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    v4m_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready),
        .item       (item)
    );

    v4m_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_data  (item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_item)
    );

    v4m_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
